// ===== rtl/mctb_pkg.sv =====
// Shared types and constants for the one-shot timer bank.
package mctb_pkg;

    // Channel count of the bank (1 to 16)
    localparam int CHANNELS = 4;

    // Field widths
    localparam int CMD_W  = 2;
    localparam int CHAN_W = 4;
    localparam int TIME_W = 24;
    localparam int MASK_W = 4;

    // Width of an index over the cells
    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SET  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_STOP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    // One channel's timer state
    typedef struct packed {
        logic [TIME_W-1:0] remaining;
        logic              armed;
    } t_chan;

    // Controller states
    typedef enum logic {
        S_IDLE,
        S_TICK
    } t_state;

    // Cell controls
    typedef struct packed {
        logic  shift;
        logic  load;
        t_chan load_data;
    } t_cell_ctrl;

endpackage

// ===== rtl/mctb_cell.sv =====
// One timer cell of the rotating ring: holds a channel's state, loads or shifts.
module mctb_cell
    import mctb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_chan      i_next,
    output t_chan      o_data
);

    t_chan r_data;
    t_chan n_data;

    // Take a direct write when idle, the neighbor's state when rotating
    always_comb begin
        n_data = r_data;
        if (i_ctrl.load) begin
            n_data = i_ctrl.load_data;
        end else if (i_ctrl.shift) begin
            n_data = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

// ===== rtl/multi_channel_oneshot_timer_bank.sv =====
// Top level of the one-shot timer bank: cell ring, shared subtractor and control.
// Set and stop transactions produce no result.
// A tick rotates the ring through the shared subtractor, one channel per cycle:
// the result is registered once the walk has passed the last channel, and the
// next transaction is taken while the result is shown when it leaves at once;
// input stalls during a tick and while a result waits. Sync active-low reset
// disarms every channel and drops any pending result.
module multi_channel_oneshot_timer_bank
    import mctb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [CHAN_W-1:0] i_channel,
    input  logic [TIME_W-1:0] i_amount,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [MASK_W-1:0] o_expired_mask
);

    t_state            r_state;
    t_state            n_state;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  n_idx;
    logic [TIME_W-1:0] r_amount;
    logic [MASK_W-1:0] r_mask;
    logic [MASK_W-1:0] n_mask;
    logic              r_out_valid;
    logic [MASK_W-1:0] r_out_mask;

    logic              in_accept;
    logic              tick_accept;
    logic              write_accept;
    logic              chan_in_range;
    logic              last_step;
    logic              shift_en;
    logic              expire;
    logic [MASK_W-1:0] step_bits;
    t_chan             head;
    t_chan             head_upd;
    t_chan             write_data;
    t_chan             cell_out [CHANNELS];
    t_cell_ctrl        cell_ctrl [CHANNELS];

    assign in_accept     = i_in_valid && o_in_ready;
    assign tick_accept   = in_accept && (i_command == CMD_TICK);
    assign chan_in_range = ({1'b0, i_channel} < (CHAN_W + 1)'(CHANNELS));
    assign write_accept  = in_accept && chan_in_range
                           && ((i_command == CMD_SET) || (i_command == CMD_STOP));
    assign last_step     = (r_idx == IDX_W'(CHANNELS - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (tick_accept) begin
                    n_state = S_TICK;
                end
            end
            S_TICK: begin
                if (last_step) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Controller outputs
    always_comb begin
        o_in_ready = 1'b0;
        shift_en   = 1'b0;
        case (r_state)
            S_IDLE: o_in_ready = !r_out_valid || i_out_ready;
            S_TICK: shift_en   = 1'b1;
            default: begin
                o_in_ready = 1'b0;
                shift_en   = 1'b0;
            end
        endcase
    end

    // Build the value written by set or stop
    always_comb begin
        if (i_command == CMD_SET) begin
            write_data.remaining = i_amount;
            write_data.armed     = 1'b1;
        end else begin
            write_data.remaining = '0;
            write_data.armed     = 1'b0;
        end
    end

    // Update the channel at the head of the ring
    assign head   = cell_out[0];
    assign expire = head.armed && (r_amount >= head.remaining);
    always_comb begin
        head_upd = head;
        if (expire) begin
            head_upd = '0;
        end else if (head.armed) begin
            head_upd.remaining = head.remaining - r_amount;
        end
    end

    // Cell ring: each cell takes from the one above, the last from the head
    for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
        assign cell_ctrl[g].shift     = shift_en;
        assign cell_ctrl[g].load      = write_accept && (i_channel == CHAN_W'(g));
        assign cell_ctrl[g].load_data = write_data;
        if (g == CHANNELS - 1) begin : g_tail
            mctb_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (cell_ctrl[g]),
                .i_next  (head_upd),
                .o_data  (cell_out[g])
            );
        end else begin : g_body
            mctb_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctrl  (cell_ctrl[g]),
                .i_next  (cell_out[g + 1]),
                .o_data  (cell_out[g])
            );
        end
    end

    // Mark the head channel in the mask when it expires and is reportable
    for (genvar b = 0; b < MASK_W; b++) begin : g_bit
        if (b < CHANNELS) begin : g_used
            assign step_bits[b] = expire && (r_idx == IDX_W'(b));
        end else begin : g_unused
            assign step_bits[b] = 1'b0;
        end
    end

    // Advance the step counter and accumulate the mask
    always_comb begin
        n_idx  = r_idx;
        n_mask = r_mask;
        if (tick_accept) begin
            n_idx  = '0;
            n_mask = '0;
        end else if (shift_en) begin
            n_mask = r_mask | step_bits;
            n_idx  = last_step ? '0 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_mask  <= n_mask;
            if (shift_en && last_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the elapsed time and the finished mask
    always_ff @(posedge i_clk) begin
        if (tick_accept) begin
            r_amount <= i_amount;
        end
        if (shift_en && last_step) begin
            r_out_mask <= n_mask;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_expired_mask = r_out_mask;

    // The output register is empty while a tick is in progress
    a_out_empty_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TICK |-> !r_out_valid)
        else $error("output pending during tick");

    // An accepted tick starts a walk at the first channel
    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_accept |=> (r_state == S_TICK) && (r_idx == '0))
        else $error("tick did not start at channel 0");

    // The walk does not stop before the last channel
    a_tick_continue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK) && !last_step |=> r_state == S_TICK)
        else $error("tick walk ended early");

    // The last step delivers a result
    a_tick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK) && last_step |=> r_out_valid && (r_state == S_IDLE))
        else $error("tick produced no result");

    // The ring is aligned whenever idle
    a_idle_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_idx == '0)
        else $error("ring misaligned in idle");

endmodule
